// ----- design/tmie_pkg.sv -----
// Shared widths, defaults and instruction codes for the tape machine execution unit.
// Depends on nothing; tmie_exec, the top level and the testbench import it.
`timescale 1ns / 1ps

package tmie_pkg;

   localparam int PC_W               = 17;
   localparam int AMOUNT_W           = 17;
   localparam int KIND_W             = 3;
   localparam int BYTE_W             = 8;

   localparam int TAPE_DEPTH_DEFAULT = 32768;
   localparam int PROGRAM_DEPTH      = 65536;

   // Magnitude of the most negative amount; pointer offsets are biased by a
   // multiple of the tape depth at least this large.
   localparam int AMOUNT_SPAN        = 65536;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD  = 3'd0,
      KIND_MOVE = 3'd1,
      KIND_OUT  = 3'd2,
      KIND_IN   = 3'd3,
      KIND_JZ   = 3'd4,
      KIND_JNZ  = 3'd5
   } kind_type;

endpackage

// ----- design/tmie_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// Read during write to the same address returns the old contents.
`timescale 1ns / 1ps

module tmie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/tmie_clear.sv -----
// Post-reset sweep that writes zero to every tape cell, one cell per cycle.
// Depends on nothing but its depth parameter.
`timescale 1ns / 1ps

module tmie_clear #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   output logic                     clear_busy,
   output logic [$clog2(DEPTH)-1:0] clear_addr
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic          busy_ff;
   logic          busy_in;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] addr_in;

   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (busy_ff) begin
         if (addr_ff == LAST_ADDR) begin
            busy_in = 1'b0;
         end else begin
            addr_in = addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   assign clear_busy = busy_ff;
   assign clear_addr = addr_ff;

endmodule

// ----- design/tmie_exec.sv -----
// Execute stage: pointer offset reduction, tape read-modify-write with forwarding,
// program counter and pointer state, output register. Uses tmie_pkg.
`timescale 1ns / 1ps

module tmie_exec import tmie_pkg::*; #(
   parameter int TAPE_DEPTH = TAPE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [PC_W-1:0]               csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [KIND_W-1:0]             req_kind,
   input  logic signed [AMOUNT_W-1:0]    req_amount,
   input  logic [BYTE_W-1:0]             req_in_byte,
   input  logic                          req_in_present,
   input  logic                          clear_busy,
   output logic                          rd_en,
   output logic [$clog2(TAPE_DEPTH)-1:0] rd_addr,
   input  logic [BYTE_W-1:0]             rd_data,
   output logic                          wr_en,
   output logic [$clog2(TAPE_DEPTH)-1:0] wr_addr,
   output logic [BYTE_W-1:0]             wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [PC_W-1:0]               rsp_next_pc,
   output logic                          rsp_out_valid,
   output logic [BYTE_W-1:0]             rsp_out_byte,
   output logic                          rsp_halted
);

   localparam int AW = $clog2(TAPE_DEPTH);
   // Bias is a multiple of the depth, so (amount + BIAS) mod depth equals amount mod depth.
   localparam longint BIAS = longint'(TAPE_DEPTH)
      * ((longint'(AMOUNT_SPAN) + longint'(TAPE_DEPTH) - 1) / longint'(TAPE_DEPTH));
   localparam int UW = $clog2(BIAS + longint'(AMOUNT_SPAN));
   localparam int SH = UW + AW;
   localparam longint RECIP = (longint'(1) << SH) / longint'(TAPE_DEPTH);
   localparam int RW = UW + 1;
   localparam int PW = UW + RW;
   localparam logic [AW:0] DEPTH_W = (AW+1)'(TAPE_DEPTH);

   // Handshake
   logic accept;
   logic out_free;
   logic retire;

   // Offset reduction, first half
   logic [UW-1:0] off_u;
   logic [PW-1:0] off_prod;
   logic [UW-1:0] off_quot;

   // Execute stage registers
   logic                       ex_valid_ff, ex_valid_in;
   logic [KIND_W-1:0]          ex_kind_ff;
   logic signed [AMOUNT_W-1:0] ex_amount_ff;
   logic [BYTE_W-1:0]          ex_in_byte_ff;
   logic                       ex_in_present_ff;
   logic [UW-1:0]              ex_quot_ff;
   logic [AW:0]                ex_ulo_ff;

   // Architectural state
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [PC_W-1:0]   len_ff, len_in;
   logic              fwd_ff, fwd_in;
   logic [BYTE_W-1:0] fwd_data_ff, fwd_data_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PC_W-1:0]   rsp_next_pc_ff;
   logic              rsp_out_valid_ff;
   logic [BYTE_W-1:0] rsp_out_byte_ff;
   logic              rsp_halted_ff;

   // Execute logic
   logic [AW:0]         quot_times_depth;
   logic [AW:0]         rem_raw;
   logic [AW-1:0]       delta_mod;
   logic [AW:0]         ptr_sum;
   logic [AW-1:0]       ptr_moved;
   logic                run;
   logic [BYTE_W-1:0]   cur_cell;
   logic [AMOUNT_W-1:0] amt_bits;
   logic [PC_W-1:0]     next_pc;
   logic [AW-1:0]       ptr_next;
   logic [BYTE_W-1:0]   new_cell;
   logic                cell_we;
   logic                emit;
   logic                halted_next;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign retire    = ex_valid_ff && out_free;
   assign req_ready = !clear_busy && (!ex_valid_ff || out_free);
   assign accept    = req_valid && req_ready;

   // Floor division of the biased amount by the depth through a reciprocal; the
   // quotient can be one low, which the remainder correction below absorbs.
   assign off_u    = UW'(longint'(req_amount) + BIAS);
   assign off_prod = PW'(off_u) * PW'(RECIP);
   assign off_quot = UW'(off_prod >> SH);

   assign quot_times_depth = (AW+1)'(longint'(ex_quot_ff) * longint'(TAPE_DEPTH));
   assign rem_raw   = ex_ulo_ff - quot_times_depth;
   assign delta_mod = (rem_raw >= DEPTH_W) ? AW'(rem_raw - DEPTH_W) : AW'(rem_raw);
   assign ptr_sum   = {1'b0, ptr_ff} + {1'b0, delta_mod};
   assign ptr_moved = (ptr_sum >= DEPTH_W) ? AW'(ptr_sum - DEPTH_W) : AW'(ptr_sum);

   assign run      = ex_valid_ff && (pc_ff < len_ff);
   assign cur_cell = fwd_ff ? fwd_data_ff : rd_data;
   assign amt_bits = ex_amount_ff;

   always_comb begin
      next_pc  = pc_ff + 1'b1;
      ptr_next = ptr_ff;
      new_cell = cur_cell;
      cell_we  = 1'b0;
      emit     = 1'b0;
      unique case (ex_kind_ff)
         KIND_ADD: begin
            new_cell = cur_cell + ex_amount_ff[BYTE_W-1:0];
            cell_we  = 1'b1;
         end
         KIND_MOVE: begin
            ptr_next = ptr_moved;
         end
         KIND_OUT: begin
            emit = 1'b1;
         end
         KIND_IN: begin
            if (ex_in_present_ff) begin
               new_cell = ex_in_byte_ff;
               cell_we  = 1'b1;
            end
         end
         KIND_JZ: begin
            if (cur_cell == '0) begin
               next_pc = pc_ff + amt_bits + 1'b1;
            end
         end
         KIND_JNZ: begin
            if (cur_cell != '0) begin
               next_pc = pc_ff - amt_bits + 1'b1;
            end
         end
         default: begin
         end
      endcase
      // A halted machine leaves every piece of state alone.
      if (!run) begin
         next_pc  = pc_ff;
         ptr_next = ptr_ff;
         cell_we  = 1'b0;
         emit     = 1'b0;
      end
   end

   assign halted_next = next_pc >= len_ff;

   // The next beat reads at the pointer this instruction leaves behind. A write
   // never coincides with a move, so a write always targets that same cell.
   assign rd_en   = accept;
   assign rd_addr = ptr_next;
   assign wr_en   = retire && cell_we;
   assign wr_addr = ptr_ff;
   assign wr_data = new_cell;

   always_comb begin
      ex_valid_in  = ex_valid_ff;
      pc_in        = pc_ff;
      ptr_in       = ptr_ff;
      len_in       = len_ff;
      fwd_in       = fwd_ff;
      fwd_data_in  = fwd_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (retire) begin
         ex_valid_in = 1'b0;
         pc_in       = next_pc;
         ptr_in      = ptr_next;
      end
      if (accept) begin
         ex_valid_in = 1'b1;
         fwd_in      = wr_en;
         fwd_data_in = new_cell;
      end
      if (csr_write_enable) begin
         if (int'(csr_write_data) > PROGRAM_DEPTH) begin
            len_in = PC_W'(PROGRAM_DEPTH);
         end else begin
            len_in = csr_write_data;
         end
      end
      if (retire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         pc_ff        <= '0;
         ptr_ff       <= '0;
         len_ff       <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         pc_ff        <= pc_in;
         ptr_ff       <= ptr_in;
         len_ff       <= len_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= fwd_data_in;
      if (accept) begin
         ex_kind_ff       <= req_kind;
         ex_amount_ff     <= req_amount;
         ex_in_byte_ff    <= req_in_byte;
         ex_in_present_ff <= req_in_present;
         ex_quot_ff       <= off_quot;
         ex_ulo_ff        <= (AW+1)'(off_u);
      end
      if (retire) begin
         rsp_next_pc_ff   <= next_pc;
         rsp_out_valid_ff <= emit;
         rsp_out_byte_ff  <= emit ? cur_cell : '0;
         rsp_halted_ff    <= halted_next;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_pc   = rsp_next_pc_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_halted    = rsp_halted_ff;

`ifndef SYNTHESIS
   a_ex_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      ex_valid_ff && !out_free |=> ex_valid_ff && $stable(ex_amount_ff) && $stable(pc_ff))
      else $error("execute stage lost its instruction while the output was stalled");

   a_retire_fills_output: assert property (@(posedge clock) disable iff (reset)
      retire |=> rsp_valid_ff)
      else $error("retired instruction did not reach the output register");

   a_pointer_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, ptr_ff} < DEPTH_W)
      else $error("cell pointer left the tape");

   a_halt_is_quiet: assert property (@(posedge clock) disable iff (reset)
      retire && !run |=> rsp_halted_ff && !rsp_out_valid_ff && (rsp_out_byte_ff == '0))
      else $error("halted step produced output or cleared the halt flag");

   a_no_work_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !ex_valid_ff && !wr_en)
      else $error("instruction in flight during the tape clearing sweep");
`endif

endmodule

// ----- design/tape_machine_instruction_executor_unit.sv -----
// Top level of the tape machine execution unit: clearing sweep, execute stage, tape RAM.
// Uses tmie_pkg, tmie_clear, tmie_exec and tmie_ram.
`timescale 1ns / 1ps

// Executes one folded tape-machine instruction per beat and returns one result
// beat per instruction (next program counter, emitted byte, halt flag). The unit
// sustains one instruction per clock while rsp_ready stays high: the tape cell is
// read from the RAM's read port in the cycle a beat is accepted, the
// instruction then executes and writes the cell back through the write port as it
// moves into the output register, and a cell written by one instruction is
// forwarded to an instruction that follows right behind it. A result goes from the
// execute stage registers through the output register to rsp_valid. While a result
// waits on rsp_ready, one more beat can enter the execute stage, after which
// req_ready stays low until the waiting result is taken. After reset a sweep
// writes zero to every tape cell, one cell per cycle, and req_ready stays low until
// it ends; program_length writes on the csr port are taken as at any other time.
module tape_machine_instruction_executor_unit import tmie_pkg::*; #(
   parameter int TAPE_DEPTH = TAPE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [PC_W-1:0]            csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic signed [AMOUNT_W-1:0] req_amount,
   input  logic [BYTE_W-1:0]          req_in_byte,
   input  logic                       req_in_present,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [PC_W-1:0]            rsp_next_pc,
   output logic                       rsp_out_valid,
   output logic [BYTE_W-1:0]          rsp_out_byte,
   output logic                       rsp_halted
);

   localparam int TAPE_AW = $clog2(TAPE_DEPTH);

   logic               clear_busy;
   logic [TAPE_AW-1:0] clear_addr;
   logic               ex_rd_en;
   logic [TAPE_AW-1:0] ex_rd_addr;
   logic [BYTE_W-1:0]  ram_rd_data;
   logic               ex_wr_en;
   logic [TAPE_AW-1:0] ex_wr_addr;
   logic [BYTE_W-1:0]  ex_wr_data;
   logic               ram_wr_en;
   logic [TAPE_AW-1:0] ram_wr_addr;
   logic [BYTE_W-1:0]  ram_wr_data;

   tmie_clear #(
      .DEPTH (TAPE_DEPTH)
   ) u_clear (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .clear_addr (clear_addr)
   );

   tmie_exec #(
      .TAPE_DEPTH (TAPE_DEPTH)
   ) u_exec (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_amount       (req_amount),
      .req_in_byte      (req_in_byte),
      .req_in_present   (req_in_present),
      .clear_busy       (clear_busy),
      .rd_en            (ex_rd_en),
      .rd_addr          (ex_rd_addr),
      .rd_data          (ram_rd_data),
      .wr_en            (ex_wr_en),
      .wr_addr          (ex_wr_addr),
      .wr_data          (ex_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_halted       (rsp_halted)
   );

   // The clearing sweep owns the write port until it finishes.
   assign ram_wr_en   = clear_busy || ex_wr_en;
   assign ram_wr_addr = clear_busy ? clear_addr : ex_wr_addr;
   assign ram_wr_data = clear_busy ? '0 : ex_wr_data;

   tmie_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TAPE_DEPTH)
   ) u_tape (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ex_rd_en),
      .rd_addr (ex_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the tape machine execution unit: stimulus table rows, random
// instruction blocks, closing rows, checked beat by beat against predicted or table results.
// Depends on tmie_pkg and tape_machine_instruction_executor_unit.
`timescale 1ns / 1ps

module tb_top;
   import tmie_pkg::*;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 7;
   localparam int QUIET_LIMIT   = 150000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_BLOCKS = 11;
   localparam int BLOCK_ITEMS   = 100;
   localparam int PTR_W         = $clog2(TAPE_DEPTH_DEFAULT);

   localparam logic [KIND_W-1:0]   KIND_SPARE_LO    = 3'd6;
   localparam logic [KIND_W-1:0]   KIND_SPARE_HI    = 3'd7;
   localparam logic [AMOUNT_W-1:0] AMOUNT_MAX       = 17'h0FFFF;
   localparam logic [AMOUNT_W-1:0] AMOUNT_MIN       = 17'h10000;
   localparam logic [AMOUNT_W-1:0] AMOUNT_MINUS_ONE = 17'h1FFFF;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [AMOUNT_W-1:0] amount;
      logic [BYTE_W-1:0]   in_byte;
      logic                in_present;
   } instr_type;

   typedef struct packed {
      logic [PC_W-1:0]   next_pc;
      logic              out_valid;
      logic [BYTE_W-1:0] out_byte;
      logic              halted;
   } step_result_type;

   typedef struct packed {
      instr_type       ins;
      logic            known;
      step_result_type want;
   } stim_row_type;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [PC_W-1:0]            csr_write_data   = '0;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [KIND_W-1:0]          req_kind         = '0;
   logic signed [AMOUNT_W-1:0] req_amount       = '0;
   logic [BYTE_W-1:0]          req_in_byte      = '0;
   logic                       req_in_present   = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic [PC_W-1:0]            rsp_next_pc;
   logic                       rsp_out_valid;
   logic [BYTE_W-1:0]          rsp_out_byte;
   logic                       rsp_halted;

   // Predicted machine state, updated as each instruction beat is accepted.
   logic [BYTE_W-1:0] tape_model [TAPE_DEPTH_DEFAULT];
   logic [PTR_W-1:0]  ptr_model;
   logic [PC_W-1:0]   pc_model;
   logic [PC_W-1:0]   length_model;

   step_result_type pending_results [$];
   stim_row_type    stim_table [$];
   int              mismatch_count = 0;
   int              send_idle_pct  = 0;
   int              recv_idle_pct  = 0;
   int              hold_request   = 0;
   int              open_first;
   int              close_first;

   tape_machine_instruction_executor_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_amount       (req_amount),
      .req_in_byte      (req_in_byte),
      .req_in_present   (req_in_present),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_halted       (rsp_halted)
   );

   always #CLOCK_HALF clock = ~clock;

   function automatic step_result_type execute_instruction(instr_type ins);
      step_result_type   r;
      logic [PC_W-1:0]   next;
      logic [BYTE_W-1:0] cur_cell;
      r        = '0;
      cur_cell = tape_model[ptr_model];
      if (pc_model >= length_model) begin
         r.next_pc = pc_model;
         r.halted  = 1'b1;
         return r;
      end
      next = pc_model + 1'b1;
      case (ins.kind)
         KIND_ADD:  tape_model[ptr_model] = cur_cell + ins.amount[BYTE_W-1:0];
         // The tape depth is a power of two, so the low pointer bits of the
         // two's complement sum give the wrapped pointer in both directions.
         KIND_MOVE: ptr_model = ptr_model + ins.amount[PTR_W-1:0];
         KIND_OUT: begin
            r.out_valid = 1'b1;
            r.out_byte  = cur_cell;
         end
         KIND_IN:   if (ins.in_present) tape_model[ptr_model] = ins.in_byte;
         KIND_JZ:   if (cur_cell == '0) next = pc_model + ins.amount + 1'b1;
         KIND_JNZ:  if (cur_cell != '0) next = pc_model - ins.amount + 1'b1;
         default: ;
      endcase
      pc_model  = next;
      r.next_pc = next;
      r.halted  = (next >= length_model);
      return r;
   endfunction

   function automatic logic [AMOUNT_W-1:0] small_amount(int reach);
      return AMOUNT_W'(int'($urandom_range(0, 2 * reach)) - reach);
   endfunction

   // Jumps that will be taken land inside the loaded program, so the counter never
   // runs past the largest program; untaken jumps carry any distance at all.
   function automatic instr_type random_instruction();
      instr_type ins;
      int        pick;
      int        target;
      bit        taken;
      ins.in_byte    = BYTE_W'($urandom_range(0, 255));
      ins.in_present = ($urandom_range(0, 99) < 85);
      ins.amount     = AMOUNT_W'($urandom_range(0, 131071));
      pick           = $urandom_range(0, 99);
      if (pick < 25) begin
         ins.kind = KIND_ADD;
         if (pick < 12) ins.amount = small_amount(8);
      end else if (pick < 40) begin
         ins.kind = KIND_MOVE;
         if (pick < 37) ins.amount = small_amount(3);
      end else if (pick < 60) begin
         ins.kind = KIND_OUT;
      end else if (pick < 75) begin
         ins.kind = KIND_IN;
      end else if (pick < 95) begin
         ins.kind = (pick < 85) ? KIND_JZ : KIND_JNZ;
         taken    = (ins.kind == KIND_JZ) ? (tape_model[ptr_model] == '0)
                                          : (tape_model[ptr_model] != '0);
         if (taken && pc_model < length_model) begin
            target = $urandom_range(0, int'(length_model) - 1);
            if (ins.kind == KIND_JZ) ins.amount = AMOUNT_W'(target - int'(pc_model) - 1);
            else                     ins.amount = AMOUNT_W'(int'(pc_model) + 1 - target);
         end
      end else begin
         ins.kind = (pick < 97) ? KIND_SPARE_LO : KIND_SPARE_HI;
      end
      return ins;
   endfunction

   task automatic add_row(input logic [KIND_W-1:0] kind, input logic [AMOUNT_W-1:0] amount,
                          input logic [BYTE_W-1:0] in_byte, input logic present,
                          input logic known, input step_result_type want);
      stim_row_type row;
      row.ins.kind       = kind;
      row.ins.amount     = amount;
      row.ins.in_byte    = in_byte;
      row.ins.in_present = present;
      row.known          = known;
      row.want           = want;
      stim_table.push_back(row);
   endtask

   // Entered and left just after a falling edge.
   task automatic send_instruction(input instr_type ins, input logic known,
                                   input step_result_type want);
      step_result_type predicted;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_kind       <= ins.kind;
      req_amount     <= ins.amount;
      req_in_byte    <= ins.in_byte;
      req_in_present <= ins.in_present;
      do @(posedge clock); while (!req_ready);
      predicted = execute_instruction(ins);
      pending_results.push_back(known ? want : predicted);
      @(negedge clock);
   endtask

   task automatic run_rows(input int first, input int last);
      for (int r = first; r < last; r++)
         send_instruction(stim_table[r].ins, stim_table[r].known, stim_table[r].want);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_length(input logic [PC_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      length_model = (value > PROGRAM_DEPTH) ? PC_W'(PROGRAM_DEPTH) : value;
   endtask

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      step_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: next_pc %0d", rsp_next_pc);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_next_pc !== want.next_pc) begin
               $error("next_pc: expected %0d, actual %0d", want.next_pc, rsp_next_pc);
               mismatch_count++;
            end
            if (rsp_out_valid !== want.out_valid) begin
               $error("out_valid: expected %0b, actual %0b", want.out_valid, rsp_out_valid);
               mismatch_count++;
            end
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, actual %02h", want.out_byte, rsp_out_byte);
               mismatch_count++;
            end
            if (rsp_halted !== want.halted) begin
               $error("halted: expected %0b, actual %0b", want.halted, rsp_halted);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      logic [PC_W-1:0] new_length;
      for (int a = 0; a < TAPE_DEPTH_DEFAULT; a++) tape_model[a] = '0;
      ptr_model    = '0;
      pc_model     = '0;
      length_model = '0;

      // With a zero program length nothing runs and the counter stays put.
      add_row(KIND_ADD, 17'd5, 8'h00, 1'b1, 1'b1,
              step_result_type'({17'd0, 1'b0, 8'h00, 1'b1}));
      open_first = stim_table.size();
      add_row(KIND_OUT, '0, 8'h00, 1'b1, 1'b1,
              step_result_type'({17'd1, 1'b1, 8'h00, 1'b0}));
      add_row(KIND_ADD, AMOUNT_MAX, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_ADD, AMOUNT_MIN, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_OUT, '0, 8'h00, 1'b1, 1'b1,
              step_result_type'({17'd4, 1'b1, 8'hFF, 1'b0}));
      add_row(KIND_ADD, 17'd1, 8'hFF, 1'b0, 1'b0, '0);
      add_row(KIND_MOVE, AMOUNT_MINUS_ONE, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_ADD, 17'd7, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_OUT, '0, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_MOVE, AMOUNT_MAX, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_MOVE, AMOUNT_MIN, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_OUT, '0, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_IN, '0, 8'hAB, 1'b1, 1'b0, '0);
      add_row(KIND_IN, '0, 8'h55, 1'b0, 1'b0, '0);
      add_row(KIND_OUT, '0, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_JZ, 17'd100, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_IN, '0, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_JZ, 17'd3, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_JNZ, 17'd5, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_ADD, 17'd1, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_JNZ, 17'd2, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_SPARE_LO, AMOUNT_MAX, 8'hFF, 1'b1, 1'b0, '0);
      add_row(KIND_SPARE_HI, AMOUNT_MIN, 8'h00, 1'b0, 1'b0, '0);
      add_row(KIND_IN, '0, 8'hFF, 1'b1, 1'b0, '0);
      add_row(KIND_OUT, '0, 8'h00, 1'b1, 1'b0, '0);
      close_first = stim_table.size();
      // A taken jump far backward wraps the counter past the program, which halts for good.
      add_row(KIND_IN, '0, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_JZ, AMOUNT_MIN, 8'h00, 1'b1, 1'b0, '0);
      add_row(KIND_ADD, 17'd1, 8'h00, 1'b1, 1'b0, '0);

      send_idle_pct = 35;
      recv_idle_pct = 51;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_length('0);
      run_rows(0, open_first);
      go_idle();
      write_length('1);
      run_rows(open_first, close_first);

      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         go_idle();
         if (blk < 4) begin
            send_idle_pct = 35;
            recv_idle_pct = 51;
         end else if (blk < 8) begin
            send_idle_pct = 51;
            recv_idle_pct = 35;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case ($urandom_range(0, 4))
            0, 1:    new_length = PC_W'(PROGRAM_DEPTH);
            2:       new_length = '1;
            default: new_length = pc_model + PC_W'($urandom_range(30, 150));
         endcase
         // The first block gets a short program, 40 instructions past the counter, to run off its end.
         if (blk == 0) new_length = pc_model + PC_W'(40);
         write_length(new_length);
         for (int n = 0; n < BLOCK_ITEMS; n++) begin
            if ((blk == 2 || blk == 9) && n == 20) hold_request = LONG_HOLD;
            if (blk == 1 && n == 50) go_idle();
            send_instruction(random_instruction(), 1'b0, '0);
         end
      end

      go_idle();
      write_length(PC_W'(PROGRAM_DEPTH));
      run_rows(close_first, stim_table.size());
      go_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
